// ===== rtl/core/uvs_pkg.sv =====
package uvs_pkg;

    localparam int MAX_SEGMENTS_DEF    = 255;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam logic [15:0] X_RADIUS_RST = 16'd256;
    localparam logic [15:0] Y_RADIUS_RST = 16'd256;
    localparam logic [15:0] Z_RADIUS_RST = 16'd256;
    localparam logic [7:0]  COL_CNT_RST  = 8'd32;
    localparam logic [7:0]  ROW_CNT_RST  = 8'd16;

    typedef enum logic [2:0] {
        REG_X_RADIUS = 3'd0,
        REG_Y_RADIUS = 3'd1,
        REG_Z_RADIUS = 3'd2,
        REG_COL_CNT  = 3'd3,
        REG_ROW_CNT  = 3'd4
    } reg_idx_t;

    // quarter-wave sample in Q1.14, fixed-point Taylor series;
    // the quarter has 2^qbits steps
    function automatic logic [14:0] quarter_wave(input longint unsigned m,
                                                 input int qbits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        x = (m * 64'd1686629713) >> qbits;
        x2 = (x * x) >> 30;
        sum = x;
        term = ((x * x2) >> 30) / 64'd6;
        sum = sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum = sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum = sum - term;
        sum = (sum + 64'd32768) >> 16;
        if (sum > 64'd16384)
            sum = 64'd16384;
        return sum[14:0];
    endfunction

endpackage

// ===== rtl/core/uv_sphere_mesh_generator.sv =====
// UV sphere vertex generator. One grid point (column, row) is accepted per
// cycle (busy is always low); its result appears on the output ports with
// done high, in order, for one cycle only: the receiver cannot stall it.
// The pipeline steps are: reciprocal multiply, fraction correction,
// sine/cosine table lookup, trig products, radius products. Registers are
// written over APB and should be changed only with no points in flight.
module uv_sphere_mesh_generator
    import uvs_pkg::*;
#(
    parameter int MAX_SEGMENTS    = MAX_SEGMENTS_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic [7:0]         column,
    input  logic [7:0]         row,
    output logic               done,
    output logic signed [16:0] pos_x,
    output logic signed [16:0] pos_y,
    output logic signed [16:0] pos_z,
    output logic [15:0]        corner_a,
    output logic [15:0]        corner_b,
    output logic [15:0]        corner_c,
    output logic [15:0]        corner_d,
    output logic [15:0]        corner_e,
    output logic [15:0]        corner_f,
    output logic               quad_valid,
    output logic               out_of_grid
);
    localparam int TB  = SINE_TABLE_BITS;
    localparam int NT  = 1 << TB;
    localparam int QT  = NT / 4;
    localparam logic [7:0] MAXS = 8'(MAX_SEGMENTS);

    logic [15:0] x_radius_reg, y_radius_reg, z_radius_reg;
    logic [7:0]  col_cnt_reg, row_cnt_reg;
    logic        wr_en;
    reg_idx_t    widx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign wr_en  = psel && penable && pwrite && pready;
    assign widx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_radius_reg <= X_RADIUS_RST;
            y_radius_reg <= Y_RADIUS_RST;
            z_radius_reg <= Z_RADIUS_RST;
            col_cnt_reg  <= COL_CNT_RST;
            row_cnt_reg  <= ROW_CNT_RST;
        end
        else if (wr_en)
        begin
            unique case (widx)
                REG_X_RADIUS: x_radius_reg <= pwdata[15:0];
                REG_Y_RADIUS: y_radius_reg <= pwdata[15:0];
                REG_Z_RADIUS: z_radius_reg <= pwdata[15:0];
                REG_COL_CNT:  col_cnt_reg  <= pwdata[7:0];
                REG_ROW_CNT:  row_cnt_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            REG_X_RADIUS: prdata = {16'd0, x_radius_reg};
            REG_Y_RADIUS: prdata = {16'd0, y_radius_reg};
            REG_Z_RADIUS: prdata = {16'd0, z_radius_reg};
            REG_COL_CNT:  prdata = {24'd0, col_cnt_reg};
            REG_ROW_CNT:  prdata = {24'd0, row_cnt_reg};
            default:      prdata = '0;
        endcase
    end

    // effective counts
    logic [7:0] cols, rows;
    always_comb
    begin
        cols = (col_cnt_reg == 8'd0) ? 8'd1 : col_cnt_reg;
        if (cols > MAXS) cols = MAXS;
        rows = (row_cnt_reg == 8'd0) ? 8'd1 : row_cnt_reg;
        if (rows > MAXS) rows = MAXS;
    end

    // stage 1: flags and index arithmetic
    logic [3:0]  vld_reg;
    logic        oog1_reg, qv1_reg;
    logic [15:0] a1_reg, b1_reg;
    logic        oog_c, qv_c;
    logic [8:0]  w;

    assign oog_c = (column > cols) || (row > rows);
    assign qv_c  = (column < cols) && (row < rows);
    assign w     = {1'b0, cols} + 9'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            done    <= 1'b0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], start};
            done    <= vld_reg[3];
        end
    end

    logic [16:0] a_c, b_c;
    assign a_c = 17'({8'd0, row} * w) + 17'(column);
    assign b_c = a_c + 17'(w);

    always_ff @(posedge clk)
    begin
        oog1_reg <= oog_c;
        qv1_reg  <= qv_c;
        a1_reg   <= qv_c ? a_c[15:0] : 16'd0;
        b1_reg   <= qv_c ? b_c[15:0] : 16'd0;
    end

    // stages 1-2: angle fractions
    logic [16:0] az_q;
    logic [15:0] pol_q;
    uvs_recip #(.SH(16)) u_az  (.clk(clk), .num(column), .den(cols), .quo(az_q));
    uvs_recip #(.SH(15)) u_pol (.clk(clk), .num(row),    .den(rows), .quo(pol_q));

    logic [15:0] az2_reg, pol2_reg;
    logic        oog2_reg, qv2_reg;
    logic [15:0] a2_reg, b2_reg;
    logic [15:0] xr2_reg, yr2_reg, zr2_reg;
    always_ff @(posedge clk)
    begin
        az2_reg  <= az_q[15:0];
        pol2_reg <= pol_q;
        oog2_reg <= oog1_reg;
        qv2_reg  <= qv1_reg;
        a2_reg   <= a1_reg;
        b2_reg   <= b1_reg;
        xr2_reg  <= x_radius_reg;
        yr2_reg  <= y_radius_reg;
        zr2_reg  <= z_radius_reg;
    end

    // stage 3: table lookup, quarter wave with mirror and sign by quadrant
    logic [14:0] qtab [QT+1];
    always_comb
    begin
        for (int k = 0; k <= QT; k++)
            qtab[k] = quarter_wave(longint'(k), TB - 2);
    end

    function automatic logic signed [15:0] trig(input logic [TB-1:0] k);
        logic [TB-3:0] m;
        logic [TB-2:0] qi;
        logic [14:0]   mag;
        m   = k[TB-3:0];
        qi  = k[TB-2] ? (TB-1)'(QT) - {1'b0, m} : {1'b0, m};
        mag = qtab[qi];
        return k[TB-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    logic [TB-1:0] azi, poi;
    assign azi = az2_reg[15 -: TB];
    assign poi = pol2_reg[15 -: TB];

    logic signed [15:0] ca3_reg, sa3_reg, cp3_reg, sp3_reg;
    logic        oog3_reg, qv3_reg;
    logic [15:0] a3_reg, b3_reg, xr3_reg, yr3_reg, zr3_reg;
    always_ff @(posedge clk)
    begin
        ca3_reg  <= trig(azi + TB'(QT));
        sa3_reg  <= trig(azi);
        cp3_reg  <= trig(poi + TB'(QT));
        sp3_reg  <= trig(poi);
        oog3_reg <= oog2_reg;
        qv3_reg  <= qv2_reg;
        a3_reg   <= a2_reg;
        b3_reg   <= b2_reg;
        xr3_reg  <= xr2_reg;
        yr3_reg  <= yr2_reg;
        zr3_reg  <= zr2_reg;
    end

    // stage 4: trig products and the y radius product
    logic signed [31:0] cs4_reg, ss4_reg, py4_reg;
    logic        oog4_reg, qv4_reg;
    logic [15:0] a4_reg, b4_reg, xr4_reg, zr4_reg;
    always_ff @(posedge clk)
    begin
        cs4_reg  <= ca3_reg * sp3_reg;
        ss4_reg  <= sa3_reg * sp3_reg;
        py4_reg  <= cp3_reg * $signed({1'b0, yr3_reg});
        oog4_reg <= oog3_reg;
        qv4_reg  <= qv3_reg;
        a4_reg   <= a3_reg;
        b4_reg   <= b3_reg;
        xr4_reg  <= xr3_reg;
        zr4_reg  <= zr3_reg;
    end

    function automatic logic [16:0] trunc_sh(input logic signed [47:0] p,
                                             input int sh);
        logic [47:0] mg;
        mg = p[47] ? 48'(-p) : 48'(p);
        mg = mg >> sh;
        return p[47] ? 17'(-mg) : mg[16:0];
    endfunction

    // stage 5: radius products and output
    logic signed [47:0] px_c, pz_c, py_c;
    assign px_c = 48'(cs4_reg) * $signed({32'd0, xr4_reg});
    assign pz_c = 48'(ss4_reg) * $signed({32'd0, zr4_reg});
    assign py_c = 48'(py4_reg);

    always_ff @(posedge clk)
    begin
        out_of_grid <= oog4_reg;
        quad_valid  <= qv4_reg;
        pos_x       <= oog4_reg ? '0 : $signed(trunc_sh(px_c, 28));
        pos_y       <= oog4_reg ? '0 : $signed(trunc_sh(py_c, 14));
        pos_z       <= oog4_reg ? '0 : $signed(trunc_sh(pz_c, 28));
        corner_a    <= a4_reg;
        corner_b    <= b4_reg;
        corner_c    <= qv4_reg ? b4_reg + 16'd1 : 16'd0;
        corner_d    <= a4_reg;
        corner_e    <= qv4_reg ? b4_reg + 16'd1 : 16'd0;
        corner_f    <= qv4_reg ? a4_reg + 16'd1 : 16'd0;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(quad_valid && out_of_grid))
        else $error("quad on out-of-grid point");
    assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##5 done)
        else $error("result lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        done && out_of_grid |-> pos_x == 0 && pos_y == 0 && corner_a == 0)
        else $error("out-of-grid result not cleared");
endmodule

// ===== rtl/core/uvs_recip.sv =====
// Computes floor((v << SH) / d) for a grid fraction by multiplying by a
// per-count reciprocal table (d in 1..255, v <= d), with one correction step.
module uvs_recip
    import uvs_pkg::*;
#(
    parameter int SH = 16
)(
    input  logic              clk,
    input  logic [7:0]        num,
    input  logic [7:0]        den,
    output logic [SH:0]       quo
);
    localparam int RW = SH + 9;

    // ceil(2^(SH+8) / d), long division worked out at elaboration
    function automatic logic [RW-1:0] recip(input int d);
        longint unsigned nm;
        longint unsigned rem;
        longint unsigned r;
        nm = (64'd1 << (SH + 8)) + longint'(d) - 1;
        rem = 0;
        r = 0;
        for (int b = SH + 8; b >= 0; b--)
        begin
            rem = (rem << 1) | ((nm >> b) & 64'd1);
            r = r << 1;
            if (rem >= longint'(d))
            begin
                rem = rem - longint'(d);
                r = r | 64'd1;
            end
        end
        return r[RW-1:0];
    endfunction

    logic [RW-1:0]    rtab [256];
    logic [RW+7:0]    prod_reg;
    logic [7:0]       num_reg;
    logic [7:0]       den_reg;
    logic [RW+7:0]    prod_next;
    logic [SH+8:0]    est;
    logic [SH+16:0]   back;

    always_comb
    begin
        for (int i = 0; i < 256; i++)
            rtab[i] = (i == 0) ? '0 : recip(i);
    end

    assign prod_next = {8'd0, rtab[den]} * {{RW{1'b0}}, num};

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        num_reg  <= num;
        den_reg  <= den;
    end

    // ceil reciprocal may overshoot by one
    always_comb
    begin
        est  = prod_reg[RW+7:8];
        back = {8'd0, est} * {{(SH+9){1'b0}}, den_reg};
        if (back > ({{(SH+9){1'b0}}, num_reg} << SH))
            quo = est[SH:0] - (SH+1)'(1);
        else
            quo = est[SH:0];
    end
endmodule
